// ----- rtl/core/mbph_pkg.sv -----
// shared types and register index constants for the masked byte pattern hunter
`default_nettype none

package mbph_pkg;

    // bytes held by the pattern and mask registers
    localparam int REG_BYTES = 16;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] addr_t;
    typedef logic [2:0]  cfg_addr_t;
    typedef logic [63:0] cfg_data_t;
    typedef logic [4:0]  len_t;
    typedef logic [REG_BYTES-1:0][7:0] reg_bytes_t;

    localparam cfg_addr_t REG_PATTERN_LOW  = 3'd0;
    localparam cfg_addr_t REG_PATTERN_HIGH = 3'd1;
    localparam cfg_addr_t REG_MASK_LOW     = 3'd2;
    localparam cfg_addr_t REG_MASK_HIGH    = 3'd3;
    localparam cfg_addr_t REG_PATTERN_LEN  = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/core/mbph_cell.sv -----
// one window cell: holds a byte, passes it to the next cell, compares it under mask
`default_nettype none

module mbph_cell (
    input  wire logic             clk,
    input  wire logic             shift_en,
    input  wire mbph_pkg::byte_t  byte_in,
    input  wire mbph_pkg::byte_t  mask_byte,
    input  wire mbph_pkg::byte_t  pattern_byte,
    input  wire logic             active,
    output mbph_pkg::byte_t       byte_q,
    output logic                  hit
);
    import mbph_pkg::*;

    byte_t window_byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            window_byte_reg <= byte_in;
        end
    end

    assign byte_q = window_byte_reg;

    // cells beyond the pattern length never veto a match
    assign hit = !active || ((window_byte_reg & mask_byte) == pattern_byte);

endmodule

`default_nettype wire

// ----- rtl/core/masked_byte_pattern_hunter_core.sv -----
// top level: config registers, window cell row, match stage and output register
// an accepted byte shifts into the cell row and stage 1; a match then loads the output register
// throughput: one byte per cycle unless in_stall; the cell row shifts every accept
// in_stall rises only while the output register is full and stalled
// reset: pattern clear, masks all ones, length one, window fill empty
`default_nettype none

module masked_byte_pattern_hunter_core #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire mbph_pkg::byte_t      byte_value,
    input  wire mbph_pkg::addr_t      byte_address,
    input  wire logic                 new_search,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output mbph_pkg::addr_t           match_address,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire mbph_pkg::cfg_addr_t  cfg_index,
    input  wire mbph_pkg::cfg_data_t  cfg_data
);
    import mbph_pkg::*;

    localparam int LEN_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int FILL_W  = $clog2(LEN_CAP + 1);

    // configuration
    cfg_data_t pattern_low_reg;
    cfg_data_t pattern_high_reg;
    cfg_data_t mask_low_reg;
    cfg_data_t mask_high_reg;
    len_t      pattern_len_reg;
    len_t      len_eff;
    reg_bytes_t pattern_vec;
    reg_bytes_t mask_vec;

    // pipeline control
    logic             in_accept;
    logic             out_load_ok;
    logic             s1_advance;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    addr_t            s1_addr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] fill_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    addr_t            match_address_reg;
    logic             match_now;

    // cell row
    logic [LEN_CAP-1:0][7:0] cell_byte;
    logic [LEN_CAP-1:0][7:0] cell_mask;
    logic [LEN_CAP-1:0][7:0] cell_pattern;
    logic [LEN_CAP-1:0][3:0] cell_sel;
    logic [LEN_CAP-1:0]      cell_active;
    logic [LEN_CAP-1:0]      cell_hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            mask_low_reg     <= '1;
            mask_high_reg    <= '1;
            pattern_len_reg  <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_MASK_LOW:     mask_low_reg     <= cfg_data;
                REG_MASK_HIGH:    mask_high_reg    <= cfg_data;
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    assign pattern_vec = {pattern_high_reg, pattern_low_reg};
    assign mask_vec    = {mask_high_reg, mask_low_reg};

    // zero acts as one, anything above the cell count saturates
    always_comb
    begin
        if (pattern_len_reg == 5'd0)
        begin
            len_eff = 5'd1;
        end
        else if (pattern_len_reg > 5'(LEN_CAP))
        begin
            len_eff = 5'(LEN_CAP);
        end
        else
        begin
            len_eff = pattern_len_reg;
        end
    end

    // cell k holds the byte k places behind the newest, matched against byte len-1-k
    always_comb
    begin
        for (int k = 0; k < LEN_CAP; k++)
        begin
            cell_sel[k]     = 4'(len_eff - 5'(k) - 5'd1);
            cell_active[k]  = 5'(k) < len_eff;
            cell_mask[k]    = mask_vec[cell_sel[k]];
            cell_pattern[k] = pattern_vec[cell_sel[k]];
        end
    end

    for (genvar g = 0; g < LEN_CAP; g++)
    begin : g_cell
        byte_t cell_in;
        if (g == 0)
        begin : g_head
            assign cell_in = byte_value;
        end
        else
        begin : g_body
            assign cell_in = cell_byte[g-1];
        end

        mbph_cell u_cell (
            .clk          (clk),
            .shift_en     (in_accept),
            .byte_in      (cell_in),
            .mask_byte    (cell_mask[g]),
            .pattern_byte (cell_pattern[g]),
            .active       (cell_active[g]),
            .byte_q       (cell_byte[g]),
            .hit          (cell_hit[g])
        );
    end

    // handshake and stage advance
    assign out_load_ok = !out_valid_reg || !out_stall;
    assign s1_advance  = s1_valid_reg && out_load_ok;
    assign in_stall    = s1_valid_reg && !out_load_ok;
    assign in_accept   = in_valid && !in_stall;

    assign fill_base = new_search ? '0 : fill_reg;
    assign fill_next = (fill_base < FILL_W'(LEN_CAP)) ? fill_base + 1'b1 : fill_base;

    assign match_now = s1_valid_reg && (5'(fill_reg) >= len_eff) && (&cell_hit);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = match_now;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= byte_address;
        end
        if (s1_advance && match_now)
        begin
            match_address_reg <= s1_addr_reg - 16'(len_eff) + 16'd1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;

    // a new result only comes out of a held window compare
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a pending compare");

    // a transaction that starts a search leaves exactly one byte in the window
    a_fill_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && new_search |=> fill_reg == FILL_W'(1))
        else $error("window fill not restarted");

    // a held compare is not dropped or overwritten while the output is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && in_stall |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("pending compare lost under stall");

endmodule

`default_nettype wire
